### rtl/core/svs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svs_pkg
// Shared constants, types and the signed compare for the value sorter.
// ----------------------------------------------------------------------------
package svs_pkg;

    localparam int DATA_W      = 64;
    localparam int DEPTH_DEF   = 64;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    function automatic logic signed_less(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return a < b;
    endfunction

endpackage : svs_pkg
`default_nettype wire

### rtl/core/svs_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svs_mem
// Value store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module svs_mem
    import svs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire t_mem_ctl          i_ctl,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : svs_mem
`default_nettype wire

### rtl/core/svs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svs_ctrl
// Sequencer: inserts each loaded word into the sorted store one compare per
// step, then reads the store out in either direction.
// ----------------------------------------------------------------------------
module svs_ctrl
    import svs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [DATA_W-1:0] i_data_value,
    input  wire logic              i_last_in,
    input  wire logic              i_desc,
    output t_mem_ctl               o_mem_ctl,
    output logic      [AW-1:0]     o_waddr,
    output logic      [DATA_W-1:0] o_wdata,
    output logic      [AW-1:0]     o_raddr,
    input  wire logic [DATA_W-1:0] i_rdata,
    output logic                   o_valid,
    output logic                   o_last_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_val, n_val;
    logic              r_last, n_last;
    logic [AW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_k, n_k;
    logic              r_desc, n_desc;
    logic              r_valid, n_valid;
    logic              r_last_out, n_last_out;
    logic              emit_end;
    logic [CW-1:0]     rev_addr;

    assign emit_end = (CW'(r_k) == (r_count - CW'(1)));
    assign rev_addr = r_count - CW'(1) - CW'(r_k);

    always_comb begin
        n_state         = r_state;
        n_val           = r_val;
        n_last          = r_last;
        n_j             = r_j;
        n_count         = r_count;
        n_k             = r_k;
        n_desc          = r_desc;
        n_valid         = 1'b0;
        n_last_out      = 1'b0;
        o_mem_ctl.wr_en = 1'b0;
        o_mem_ctl.rd_en = 1'b0;
        o_waddr         = r_j;
        o_wdata         = r_val;
        o_raddr         = r_j - AW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_k    = '0;
                    n_desc = i_desc;
                    if (r_count < CW'(DEPTH)) begin
                        n_val   = i_data_value;
                        n_last  = i_last_in;
                        n_j     = r_count[AW-1:0];
                        n_state = S_INS_RD;
                    end else if (i_last_in) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_INS_RD: begin
                if (r_j == '0) begin
                    o_mem_ctl.wr_en = 1'b1;
                    n_count         = r_count + CW'(1);
                    n_state         = r_last ? S_EMIT : S_IDLE;
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_state         = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_mem_ctl.wr_en = 1'b1;
                if (signed_less(r_val, i_rdata)) begin
                    o_wdata = i_rdata;
                    n_j     = r_j - AW'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                o_mem_ctl.rd_en = 1'b1;
                o_raddr         = r_desc ? rev_addr[AW-1:0] : r_k;
                n_valid         = 1'b1;
                n_last_out      = emit_end;
                n_k             = r_k + AW'(1);
                if (emit_end) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_valid    <= 1'b0;
            r_last_out <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_last_out <= n_last_out;
            r_val      <= n_val;
            r_last     <= n_last;
            r_j        <= n_j;
            r_k        <= n_k;
            r_desc     <= n_desc;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_last_out = r_last_out;

endmodule : svs_ctrl
`default_nettype wire

### rtl/core/signed_value_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_value_sorter
// Loads a set of signed words and emits them sorted, ascending or descending.
// ----------------------------------------------------------------------------
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------
// input    | start, busy             | i_data_value, i_last_in
// result   | o_valid (one cycle)     | o_sorted_value, o_last_out
// config   | i_cfg_we                | i_cfg_wdata (sort_descending)
//
// A word is inserted into the sorted store as it arrives, one read and one
// compare-and-write per position checked, each stored word greater than it
// moving up one place. A word past the depth is dropped; busy is not raised to
// insert it. A marked word then reads the n words out while busy stays high;
// each result appears in the cycle after its read, so the last one comes once
// busy has fallen. Reset is synchronous and clears the fill count and control
// only; the store needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_value_sorter
    import svs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] i_data_value,
    input  wire logic                     i_last_in,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_wdata,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_last_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              r_desc;
    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg_we) begin
            r_desc <= i_cfg_wdata;
        end
    end

    svs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_data_value (i_data_value),
        .i_last_in    (i_last_in),
        .i_desc       (r_desc),
        .o_mem_ctl    (mem_ctl),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_valid      (o_valid),
        .o_last_out   (o_last_out)
    );

    svs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_sorted_value = rdata;

endmodule : signed_value_sorter
`default_nettype wire
